>>> rtl/orb_pkg.sv
// package for the overwriting ring buffer: sizes, codes, result types
// and the pointer step function; no dependencies
package orb_pkg;

  // storage geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PtrW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  // field widths
  localparam int unsigned WordW = 32;
  localparam int unsigned ReqW  = 7;

  // command codes
  localparam logic CmdAppend = 1'b0;
  localparam logic CmdFetch  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEmit
  } orb_state_e;

  typedef struct packed {
    logic signed [WordW-1:0] item_out;
    logic                    item_valid;
    logic                    last;
    logic [ReqW-1:0]         fetched_total;
    logic                    overwrote;
    logic                    now_empty;
  } orb_res_t;

  typedef struct packed {
    logic     load;
    orb_res_t res;
  } orb_load_t;

  // advance a ring pointer with wrap at the depth
  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(DEPTH - 1)) r = '0;
    else                       r = p + PtrW'(1);
    return r;
  endfunction

endpackage

>>> rtl/orb_in_if.sv
// input channel of the ring buffer: valid/ready word with command fields
// depends on orb_pkg
interface orb_in_if;
  import orb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [WordW-1:0] data_in;
  logic [ReqW-1:0]         request_count;

  modport source (output valid, cmd, data_in, request_count, input ready);
  modport sink   (input valid, cmd, data_in, request_count, output ready);
endinterface

>>> rtl/orb_out_if.sv
// result channel of the ring buffer: valid/ready word with result fields
// depends on orb_pkg
interface orb_out_if;
  import orb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WordW-1:0] item_out;
  logic                    item_valid;
  logic                    last;
  logic [ReqW-1:0]         fetched_total;
  logic                    overwrote;
  logic                    now_empty;

  modport source (output valid, item_out, item_valid, last, fetched_total, overwrote,
                  now_empty, input ready);
  modport sink   (input valid, item_out, item_valid, last, fetched_total, overwrote,
                  now_empty, output ready);
endinterface

>>> rtl/overwriting_ring_buffer.sv
// overwriting ring buffer of signed words, oldest dropped when full
// append: the result register loads on acceptance; the next word is taken once
// it is free; fetch of n words: the accepting cycle, then per word a store read,
// registered in the single word store, and an emit that waits for a free result
// register; an empty run gives one result on acceptance; reset clears the pointers,
// the fill count and the result register valid but not the word store
module overwriting_ring_buffer (
  input  logic    clk_i,
  input  logic    rst_ni,
  orb_in_if.sink  in_i,
  orb_out_if.source out_o
);
  import orb_pkg::*;

  orb_load_t        load;
  orb_res_t         res_q;
  logic             out_valid_q;
  logic             out_free;
  logic             we;
  logic [PtrW-1:0]  waddr;
  logic [WordW-1:0] wdata;
  logic             re;
  logic [PtrW-1:0]  raddr;
  logic [WordW-1:0] rdata;

  assign out_free = !out_valid_q || out_o.ready;

  orb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .rdata_i    (rdata),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .load_o     (load)
  );

  orb_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (load.load) res_q <= load.res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.item_out      = res_q.item_out;
  assign out_o.item_valid    = res_q.item_valid;
  assign out_o.last          = res_q.last;
  assign out_o.fetched_total = res_q.fetched_total;
  assign out_o.overwrote     = res_q.overwrote;
  assign out_o.now_empty     = res_q.now_empty;

endmodule

>>> rtl/orb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module orb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/orb_ctrl.sv
// sequencer of the ring buffer: pointers, fill count and fetch stepping
// depends on orb_pkg, orb_in_if; drives the word store ram ports
module orb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  orb_in_if.sink                        in_i,
  input  logic                          out_free_i,
  input  logic [orb_pkg::WordW-1:0]     rdata_i,
  output logic                          we_o,
  output logic [orb_pkg::PtrW-1:0]      waddr_o,
  output logic [orb_pkg::WordW-1:0]     wdata_o,
  output logic                          re_o,
  output logic [orb_pkg::PtrW-1:0]      raddr_o,
  output orb_pkg::orb_load_t            load_o
);
  import orb_pkg::*;

  orb_state_e      state_q, state_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] total_q, total_d;
  logic            accept;
  logic            full;
  logic [CntW-1:0] n_req;

  assign in_i.ready = (state_q == StIdle) && out_free_i;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CntW'(DEPTH));

  // words this fetch will return: min(request, stored)
  assign n_req = (in_i.request_count < ReqW'(cnt_q)) ? CntW'(in_i.request_count) : cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && (in_i.cmd == CmdFetch) && (n_req != '0)) state_d = StRead;
      StRead: state_d = StEmit;
      StEmit: if (out_free_i) state_d = (rem_q == CntW'(1)) ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    total_d  = total_q;
    we_o     = 1'b0;
    waddr_o  = wr_ptr_q;
    wdata_o  = in_i.data_in;
    re_o     = 1'b0;
    raddr_o  = rd_ptr_q;
    load_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          load_o.load     = 1'b1;
          load_o.res.last = 1'b1;
          if (in_i.cmd == CmdAppend) begin
            // store the word, dropping the oldest when full
            we_o     = 1'b1;
            wr_ptr_d = next_ptr(wr_ptr_q);
            if (full) begin
              rd_ptr_d             = next_ptr(rd_ptr_q);
              load_o.res.overwrote = 1'b1;
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end else begin
            // null result for an empty run, else start stepping
            load_o.load          = (n_req == '0);
            load_o.res.now_empty = (cnt_q == '0);
            rem_d                = n_req;
            total_d              = n_req;
          end
        end
      end
      StRead: begin
        re_o = 1'b1;
      end
      StEmit: begin
        if (out_free_i) begin
          load_o.load           = 1'b1;
          load_o.res.item_out   = rdata_i;
          load_o.res.item_valid = 1'b1;
          load_o.res.last       = (rem_q == CntW'(1));
          load_o.res.fetched_total = (rem_q == CntW'(1)) ? ReqW'(total_q) : '0;
          load_o.res.now_empty  = (cnt_q == CntW'(1));
          rd_ptr_d              = next_ptr(rd_ptr_q);
          cnt_d                 = cnt_q - CntW'(1);
          rem_d                 = rem_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
    end
  end

  // run length for the last word
  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

endmodule
